FILE: hw/rtl/hsrm_pkg.sv
// Shared types, constants and helpers for the heightmap sampler and ray marcher.
// Used by hsrm_sampler and heightmap_sample_and_ray_march; depends on nothing.
package hsrm_pkg;

  localparam int unsigned DEF_MAX_COLUMNS = 256;
  localparam int unsigned DEF_MAX_ROWS    = 256;
  localparam int unsigned DEF_MAX_STEPS   = 1024;

  localparam int unsigned AW  = 16;  // store address
  localparam int unsigned DW  = 16;  // raw height word
  localparam int unsigned RW  = 52;  // ray position in Q.22
  localparam int unsigned PW  = 38;  // sample point in Q.8
  localparam int unsigned HW  = 32;  // scaled corner height
  localparam int unsigned TW  = 34;  // interpolated height
  localparam int unsigned FW  = 20;  // fraction bits at most
  localparam int unsigned MAW = 35;
  localparam int unsigned MBW = 21;
  localparam int unsigned MPW = 56;

  localparam int unsigned IN_TDATA_W  = 176;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam int unsigned OUT_TUSER_W = 1;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_TRACE  = 2'd2;

  localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_CELL_SHIFT     = 2'd2;
  localparam logic [1:0] REG_VERTICAL_SCALE = 2'd3;

  localparam logic [8:0]  RST_GRID_WIDTH     = 9'd256;
  localparam logic [8:0]  RST_GRID_HEIGHT    = 9'd256;
  localparam logic [3:0]  RST_CELL_SHIFT     = 4'd6;
  localparam logic [15:0] RST_VERTICAL_SCALE = 16'd256;

  localparam logic [3:0] SHIFT_MIN = 4'd1;
  localparam logic [3:0] SHIFT_MAX = 4'd12;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [DW-1:0] data;
  } hsrm_wr_t;

  function automatic logic [23:0] sat24(input logic signed [RW-1:0] v);
    logic [23:0] r;
    if (v[RW-1:23] == '0 || v[RW-1:23] == '1) begin
      r = v[23:0];
    end else if (v[RW-1]) begin
      r = 24'h800000;
    end else begin
      r = 24'h7FFFFF;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/hsrm_sampler.sv
// Height store memory and bilinear sampler: four corner reads, scaling and three lerps.
// Depends on hsrm_pkg.
module hsrm_sampler #(
  parameter int unsigned MAX_COLUMNS = hsrm_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = hsrm_pkg::DEF_MAX_ROWS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  hsrm_pkg::hsrm_wr_t                     wr_i,
  input  logic                                   start_i,
  input  logic signed [hsrm_pkg::PW-1:0]         px_i,
  input  logic signed [hsrm_pkg::PW-1:0]         py_i,
  input  logic [3:0]                             shift_i,
  input  logic [$clog2(MAX_COLUMNS):0]           cols_i,
  input  logic [$clog2(MAX_ROWS):0]              rows_i,
  input  logic [15:0]                            vscale_i,
  output logic                                   done_o,
  output logic signed [hsrm_pkg::TW-1:0]         height_o
);
  import hsrm_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RHW = $clog2(MAX_ROWS);

  typedef enum logic [2:0] {
    S_IDLE, S_COORD, S_ROW0, S_ROW1, S_READ, S_SCALE, S_LMUL, S_LADD
  } state_e;

  state_e                 state_q;
  logic [CW-1:0]          x0_q, x1_q;
  logic [RHW-1:0]         y0_q, y1_q;
  logic [FW-1:0]          fx_q, fy_q;
  logic [AW-1:0]          base0_q, base1_q;
  logic [1:0]             corner_q, lerp_q;
  logic signed [HW-1:0]   h_q [4];
  logic signed [TW-1:0]   t0_q, t1_q, res_q;
  logic signed [MPW-1:0]  prod_q;
  logic                   done_q;
  logic [DW-1:0]          rd_q;
  logic [DW-1:0]          mem [2**AW];

  logic [4:0]             f;
  logic signed [PW-1:0]   gx, gy, gx1, gy1, wmax, hmax;
  logic [CW-1:0]          cx0, cx1;
  logic [RHW-1:0]         cy0, cy1;
  logic [20:0]            mask;
  logic [FW-1:0]          fx, fy;
  logic [RHW-1:0]         row_sel;
  logic [RHW+CW:0]        row_full;
  logic [AW-1:0]          rd_addr;
  logic signed [MAW-1:0]  mul_a;
  logic signed [MBW-1:0]  mul_b;
  logic signed [MPW-1:0]  prod, half, shv, basex, sumv;
  logic signed [TW-1:0]   basev;

  always_comb begin
    f    = 5'd8 + {1'b0, shift_i};
    gx   = px_i >>> f;
    gy   = py_i >>> f;
    gx1  = gx + $signed(PW'(1));
    gy1  = gy + $signed(PW'(1));
    wmax = $signed(PW'(cols_i)) - $signed(PW'(1));
    hmax = $signed(PW'(rows_i)) - $signed(PW'(1));
    cx0  = gx[PW-1]  ? '0 : (gx  > wmax) ? wmax[CW-1:0]  : gx[CW-1:0];
    cx1  = gx1[PW-1] ? '0 : (gx1 > wmax) ? wmax[CW-1:0]  : gx1[CW-1:0];
    cy0  = gy[PW-1]  ? '0 : (gy  > hmax) ? hmax[RHW-1:0] : gy[RHW-1:0];
    cy1  = gy1[PW-1] ? '0 : (gy1 > hmax) ? hmax[RHW-1:0] : gy1[RHW-1:0];
    mask = (21'd1 << f) - 21'd1;
    fx   = px_i[FW-1:0] & mask[FW-1:0];
    fy   = py_i[FW-1:0] & mask[FW-1:0];
    half = $signed(MPW'(1) << (f - 5'd1));
  end

  assign row_sel  = (state_q == S_ROW1) ? y1_q : y0_q;
  assign row_full = row_sel * cols_i;
  assign rd_addr  = (corner_q[1] ? base1_q : base0_q) + AW'(corner_q[0] ? x1_q : x0_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    basev = '0;
    case (state_q)
      S_SCALE: begin
        mul_a = {{(MAW-DW){rd_q[DW-1]}}, rd_q};
        mul_b = {{(MBW-16){1'b0}}, vscale_i};
      end
      S_LMUL, S_LADD: begin
        case (lerp_q)
          2'd0: begin
            mul_a = {{(MAW-HW){h_q[1][HW-1]}}, h_q[1]} - {{(MAW-HW){h_q[0][HW-1]}}, h_q[0]};
            mul_b = {1'b0, fx_q};
            basev = {{(TW-HW){h_q[0][HW-1]}}, h_q[0]};
          end
          2'd1: begin
            mul_a = {{(MAW-HW){h_q[3][HW-1]}}, h_q[3]} - {{(MAW-HW){h_q[2][HW-1]}}, h_q[2]};
            mul_b = {1'b0, fx_q};
            basev = {{(TW-HW){h_q[2][HW-1]}}, h_q[2]};
          end
          default: begin
            mul_a = {{(MAW-TW){t1_q[TW-1]}}, t1_q} - {{(MAW-TW){t0_q[TW-1]}}, t0_q};
            mul_b = {1'b0, fy_q};
            basev = t0_q;
          end
        endcase
      end
      default: ;
    endcase
    prod  = mul_a * mul_b;
    shv   = (prod_q + half) >>> f;
    basex = {{(MPW-TW){basev[TW-1]}}, basev};
    sumv  = basex + shv;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      corner_q <= '0;
      lerp_q   <= '0;
    end else begin
      done_q <= (state_q == S_LADD) && (lerp_q == 2'd2);
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_COORD;
          end
        end
        S_COORD: begin
          x0_q    <= cx0;
          x1_q    <= cx1;
          y0_q    <= cy0;
          y1_q    <= cy1;
          fx_q    <= fx;
          fy_q    <= fy;
          state_q <= S_ROW0;
        end
        S_ROW0: begin
          base0_q <= AW'(row_full);
          state_q <= S_ROW1;
        end
        S_ROW1: begin
          base1_q  <= AW'(row_full);
          corner_q <= '0;
          state_q  <= S_READ;
        end
        S_READ: begin
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          h_q[corner_q] <= prod[HW-1:0];
          corner_q      <= corner_q + 2'd1;
          if (corner_q == 2'd3) begin
            lerp_q  <= '0;
            state_q <= S_LMUL;
          end else begin
            state_q <= S_READ;
          end
        end
        S_LMUL: begin
          prod_q  <= prod;
          state_q <= S_LADD;
        end
        S_LADD: begin
          case (lerp_q)
            2'd0: begin
              t0_q    <= sumv[TW-1:0];
              lerp_q  <= 2'd1;
              state_q <= S_LMUL;
            end
            2'd1: begin
              t1_q    <= sumv[TW-1:0];
              lerp_q  <= 2'd2;
              state_q <= S_LMUL;
            end
            default: begin
              res_q   <= sumv[TW-1:0];
              state_q <= S_IDLE;
            end
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign height_o = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE) else $error("sampler started while busy");
  a_done_after_lerp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(state_q) == S_LADD && $past(lerp_q) == 2'd2)
    else $error("sample result without final lerp");
  a_scale_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCALE |-> $past(state_q) == S_READ)
    else $error("corner scaled without a read");

endmodule

FILE: hw/rtl/heightmap_sample_and_ray_march.sv
// Top level: stream ports, APB registers and the ray-march sequencer.
// Depends on hsrm_pkg and hsrm_sampler.
//
// Channel  Direction  Handshake                  Payload
// s_axis   in         tvalid/tready              tuser func, tdata command fields
// m_axis   out        tvalid/tready              tuser hit, tdata result fields
// apb      in         psel/penable/pwrite/pready grid_width, grid_height, cell_shift, scale
//
// A write or an unused code goes straight to the output state; a sample runs the sampler once.
// A trace runs the sampler once per step, up to MAX_STEPS samples, each paced by the four
// corner reads through the single memory port and the shared lerp multiplier.
// Reset restores the register defaults; the height store is undefined until written.
// A new transaction is taken whenever the sequencer is idle, even with a result waiting.
module heightmap_sample_and_ray_march #(
  parameter int unsigned MAX_COLUMNS = hsrm_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = hsrm_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_STEPS   = hsrm_pkg::DEF_MAX_STEPS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // cell_index, raw_height, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, max_dist, pad
  input  logic [hsrm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // func
  input  logic [hsrm_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // sampled_height, hit_x, hit_y, hit_z
  output logic [hsrm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // hit
  output logic [hsrm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hsrm_pkg::APB_AW-1:0]         paddr,
  input  logic [hsrm_pkg::APB_DW-1:0]         pwdata,
  output logic [hsrm_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import hsrm_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RHW = $clog2(MAX_ROWS);
  localparam int unsigned CWP = CW + 1;
  localparam int unsigned RHP = RHW + 1;
  localparam int unsigned NW  = $clog2(MAX_STEPS + 1);

  typedef enum logic [1:0] {T_IDLE, T_WAIT, T_OUT} state_e;

  state_e                state_q;
  logic [8:0]            gw_q, gh_q;
  logic [3:0]            cs_q;
  logic [15:0]           vs_q;
  logic [1:0]            func_q;
  logic signed [RW-1:0]  rx_q, ry_q, rz_q, sx_q, sy_q, sz_q, limx_q, limy_q;
  logic [NW-1:0]         n_q, step_q;
  logic                  start_q;
  logic                  start_d;
  logic [OUT_TDATA_W-1:0] res_data_q, m_data_q;
  logic                  res_hit_q, m_hit_q, m_valid_q;

  logic [CW:0]           cols_eff;
  logic [RHW:0]          rows_eff;
  logic [3:0]            s_eff;
  logic [4:0]            st;
  logic [5:0]            lst;
  logic                  accept;
  logic [1:0]            in_func;
  logic signed [RW-1:0]  px_w, py_w, pz_w, dx_w, dy_w, dz_w;
  logic [RW-1:0]         cm1, rm1;
  logic [22:0]           mds;
  logic [23:0]           nfull;
  logic [NW-1:0]         n_init;
  logic signed [PW-1:0]  qx, qy;
  logic                  smp_done;
  logic signed [TW-1:0]  th;
  logic signed [RW-1:0]  thw, nrx, nry, nrz;
  logic                  hitc, oob, last;
  hsrm_wr_t              wr;

  always_comb begin
    if (gw_q < 9'd2) begin
      cols_eff = CWP'(2);
    end else if (32'(gw_q) > 32'(MAX_COLUMNS)) begin
      cols_eff = CWP'(MAX_COLUMNS);
    end else begin
      cols_eff = CWP'(gw_q);
    end
    if (gh_q < 9'd2) begin
      rows_eff = RHP'(2);
    end else if (32'(gh_q) > 32'(MAX_ROWS)) begin
      rows_eff = RHP'(MAX_ROWS);
    end else begin
      rows_eff = RHP'(gh_q);
    end
    if (cs_q < SHIFT_MIN) begin
      s_eff = SHIFT_MIN;
    end else if (cs_q > SHIFT_MAX) begin
      s_eff = SHIFT_MAX;
    end else begin
      s_eff = cs_q;
    end
  end

  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_func = s_axis_tuser_i;
  assign st      = {1'b0, s_eff} + 5'd7;
  assign lst     = {2'b0, s_eff} + 6'd22;

  always_comb begin
    px_w  = {{(RW-24){s_axis_tdata_i[55]}}, s_axis_tdata_i[55:32]} <<< 14;
    py_w  = {{(RW-24){s_axis_tdata_i[79]}}, s_axis_tdata_i[79:56]} <<< 14;
    pz_w  = {{(RW-24){s_axis_tdata_i[103]}}, s_axis_tdata_i[103:80]} <<< 14;
    dx_w  = {{(RW-16){s_axis_tdata_i[119]}}, s_axis_tdata_i[119:104]} <<< st;
    dy_w  = {{(RW-16){s_axis_tdata_i[135]}}, s_axis_tdata_i[135:120]} <<< st;
    dz_w  = {{(RW-16){s_axis_tdata_i[151]}}, s_axis_tdata_i[151:136]} <<< st;
    cm1   = RW'(cols_eff - CWP'(1)) << lst;
    rm1   = RW'(rows_eff - RHP'(1)) << lst;
    mds   = s_axis_tdata_i[174:152] >> st;
    nfull = {1'b0, mds} + 24'd1;
    n_init = (32'(nfull) > 32'(MAX_STEPS)) ? NW'(MAX_STEPS) : NW'(nfull);
  end

  always_comb begin
    wr.en   = accept && in_func == FUNC_WRITE;
    wr.addr = s_axis_tdata_i[15:0];
    wr.data = s_axis_tdata_i[31:16];
  end

  assign qx = rx_q[RW-1:14];
  assign qy = ry_q[RW-1:14];

  hsrm_sampler #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_sampler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .start_i (start_q),
    .px_i    (qx),
    .py_i    (qy),
    .shift_i (s_eff),
    .cols_i  (cols_eff),
    .rows_i  (rows_eff),
    .vscale_i(vs_q),
    .done_o  (smp_done),
    .height_o(th)
  );

  always_comb begin
    thw  = {{(RW-TW){th[TW-1]}}, th} <<< 14;
    hitc = rz_q <= thw;
    nrx  = rx_q + sx_q;
    nry  = ry_q + sy_q;
    nrz  = rz_q + sz_q;
    oob  = nrx[RW-1] || nry[RW-1] || nrx >= limx_q || nry >= limy_q;
    last = (step_q + NW'(1)) == n_q;
  end

  always_comb begin
    start_d = 1'b0;
    if (state_q == T_IDLE) begin
      start_d = accept && (in_func == FUNC_SAMPLE || in_func == FUNC_TRACE);
    end else if (state_q == T_WAIT) begin
      start_d = smp_done && func_q != FUNC_SAMPLE && !hitc && !oob && !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= RST_GRID_WIDTH;
      gh_q <= RST_GRID_HEIGHT;
      cs_q <= RST_CELL_SHIFT;
      vs_q <= RST_VERTICAL_SCALE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_GRID_WIDTH:     gw_q <= pwdata[8:0];
        REG_GRID_HEIGHT:    gh_q <= pwdata[8:0];
        REG_CELL_SHIFT:     cs_q <= pwdata[3:0];
        REG_VERTICAL_SCALE: vs_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRID_WIDTH:     prdata = APB_DW'(gw_q);
      REG_GRID_HEIGHT:    prdata = APB_DW'(gh_q);
      REG_CELL_SHIFT:     prdata = APB_DW'(cs_q);
      REG_VERTICAL_SCALE: prdata = APB_DW'(vs_q);
      default:            prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
      step_q    <= '0;
      n_q       <= '0;
      func_q    <= FUNC_WRITE;
    end else begin
      start_q <= start_d;
      if (m_valid_q && m_axis_tready_i && state_q != T_OUT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (accept) begin
            func_q     <= in_func;
            rx_q       <= px_w;
            ry_q       <= py_w;
            rz_q       <= pz_w;
            sx_q       <= dx_w;
            sy_q       <= dy_w;
            sz_q       <= dz_w;
            limx_q     <= $signed(cm1);
            limy_q     <= $signed(rm1);
            n_q        <= n_init;
            step_q     <= '0;
            res_data_q <= '0;
            res_hit_q  <= 1'b0;
            if (in_func == FUNC_SAMPLE || in_func == FUNC_TRACE) begin
              state_q <= T_WAIT;
            end else begin
              state_q <= T_OUT;
            end
          end
        end
        T_WAIT: begin
          if (smp_done) begin
            if (func_q == FUNC_SAMPLE) begin
              res_data_q[23:0] <= sat24({{(RW-TW){th[TW-1]}}, th});
              state_q          <= T_OUT;
            end else if (hitc) begin
              res_hit_q          <= 1'b1;
              res_data_q[47:24]  <= sat24({{(RW-PW){qx[PW-1]}}, qx});
              res_data_q[71:48]  <= sat24({{(RW-PW){qy[PW-1]}}, qy});
              res_data_q[95:72]  <= sat24({{(RW-TW){th[TW-1]}}, th});
              state_q            <= T_OUT;
            end else begin
              rx_q   <= nrx;
              ry_q   <= nry;
              rz_q   <= nrz;
              step_q <= step_q + NW'(1);
              if (oob || last) begin
                state_q <= T_OUT;
              end
            end
          end
        end
        T_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_data_q;
            m_hit_q   <= res_hit_q;
            state_q   <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = state_q == T_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_hit_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_done |-> state_q == T_WAIT) else $error("sample result outside a wait");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_WAIT && func_q == FUNC_TRACE) |-> step_q < n_q)
    else $error("march ran past its step count");
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == T_OUT)
    else $error("result raised outside the output state");

endmodule
